>>> rtl/bbp_pkg.sv
// Shared types, constants and sizes for the B-spline to Bezier path converter.
package bbp_pkg;

    // Coordinate format: signed Q16.16 at this width.
    localparam int COORD_WIDTH = 32;

    // Weighted sums of up to six coordinates need three more bits plus sign room.
    localparam int SUM_WIDTH = COORD_WIDTH + 4;

    // Biased dividend for the divide-by-three pipeline.
    localparam int DIVIDEND_WIDTH   = COORD_WIDTH + 3;
    localparam int DIV_DIGITS       = (DIVIDEND_WIDTH + 1) / 2;
    localparam int DIV_PAD_WIDTH    = 2 * DIV_DIGITS;
    localparam int DIGITS_PER_STAGE = 6;
    localparam int DIV_STAGES       = (DIV_DIGITS + DIGITS_PER_STAGE - 1) / DIGITS_PER_STAGE;

    // Offset that makes every numerator positive; it is a multiple of three and
    // a multiple of 2**COORD_WIDTH after division, so the low quotient bits hold.
    localparam logic [SUM_WIDTH-1:0] DIV_BIAS = SUM_WIDTH'(3) << (COORD_WIDTH + 1);

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Input event codes.
    localparam logic [2:0] ACT_POINT      = 3'd0;
    localparam logic [2:0] ACT_LINE_START = 3'd1;
    localparam logic [2:0] ACT_LINE_END   = 3'd2;
    localparam logic [2:0] ACT_AREA_START = 3'd3;
    localparam logic [2:0] ACT_AREA_END   = 3'd4;

    // Path command codes.
    localparam logic [1:0] CMD_MOVE  = 2'd0;
    localparam logic [1:0] CMD_LINE  = 2'd1;
    localparam logic [1:0] CMD_CURVE = 2'd2;
    localparam logic [1:0] CMD_CLOSE = 2'd3;

    // Kinds of command that the back can carry out.
    typedef enum logic [2:0] {
        KIND_MOVE_P,
        KIND_LINE_P,
        KIND_LINE_SIX,
        KIND_CURVE,
        KIND_LINE_N,
        KIND_CLOSE
    } kind_t;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    typedef struct packed {
        logic [2:0] action;
        coord_t     px;
        coord_t     py;
    } in_t;

    typedef struct packed {
        logic [1:0] command;
        coord_t     ctrl1_x;
        coord_t     ctrl1_y;
        coord_t     ctrl2_x;
        coord_t     ctrl2_y;
        coord_t     end_x;
        coord_t     end_y;
        logic       last;
    } out_t;

    // One classified event: up to three commands and the points they use.
    typedef struct packed {
        kind_t [2:0] kinds;
        logic [1:0]  ncmd;
        coord_t      old_x;
        coord_t      old_y;
        coord_t      new_x;
        coord_t      new_y;
        coord_t      pt_x;
        coord_t      pt_y;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

>>> rtl/bbp_div3.sv
// Pipelined floor division by three, two quotient bits per step.
module bbp_div3 (
    input  logic                                 clk,
    input  logic                                 adv,
    input  logic [bbp_pkg::DIV_PAD_WIDTH-1:0]    num,
    output bbp_pkg::coord_t                      quo
);

    logic [bbp_pkg::DIV_PAD_WIDTH-1:0] num_reg [bbp_pkg::DIV_STAGES];
    logic [bbp_pkg::DIV_PAD_WIDTH-1:0] quo_reg [bbp_pkg::DIV_STAGES];
    logic [1:0]                        rem_reg [bbp_pkg::DIV_STAGES];

    // One radix-4 step: quotient digit and remainder of a value up to eleven.
    function automatic logic [3:0] div_step(input logic [3:0] v);
        logic [3:0] qr;
        begin
            case (v)
                4'd0:    qr = {2'd0, 2'd0};
                4'd1:    qr = {2'd0, 2'd1};
                4'd2:    qr = {2'd0, 2'd2};
                4'd3:    qr = {2'd1, 2'd0};
                4'd4:    qr = {2'd1, 2'd1};
                4'd5:    qr = {2'd1, 2'd2};
                4'd6:    qr = {2'd2, 2'd0};
                4'd7:    qr = {2'd2, 2'd1};
                4'd8:    qr = {2'd2, 2'd2};
                4'd9:    qr = {2'd3, 2'd0};
                4'd10:   qr = {2'd3, 2'd1};
                4'd11:   qr = {2'd3, 2'd2};
                default: qr = {2'd0, 2'd0};
            endcase
            return qr;
        end
    endfunction

    genvar s;
    generate
        for (s = 0; s < bbp_pkg::DIV_STAGES; s++) begin : g_stage
            logic [bbp_pkg::DIV_PAD_WIDTH-1:0] num_in;
            logic [bbp_pkg::DIV_PAD_WIDTH-1:0] quo_in;
            logic [1:0]                        rem_in;
            logic [bbp_pkg::DIV_PAD_WIDTH-1:0] quo_c;
            logic [1:0]                        rem_c;

            if (s == 0) begin : g_first
                assign num_in = num;
                assign quo_in = '0;
                assign rem_in = 2'd0;
            end
            else begin : g_next
                assign num_in = num_reg[s-1];
                assign quo_in = quo_reg[s-1];
                assign rem_in = rem_reg[s-1];
            end

            // Work this stage's digits from the most significant end.
            always_comb
            begin
                int         idx;
                int         pos;
                logic [3:0] qr;
                quo_c = quo_in;
                rem_c = rem_in;
                for (int j = 0; j < bbp_pkg::DIGITS_PER_STAGE; j++)
                begin
                    idx = s * bbp_pkg::DIGITS_PER_STAGE + j;
                    pos = (idx < bbp_pkg::DIV_DIGITS) ? (bbp_pkg::DIV_PAD_WIDTH - 2 - 2 * idx) : 0;
                    qr  = div_step({rem_c, num_in[pos +: 2]});
                    if (idx < bbp_pkg::DIV_DIGITS)
                    begin
                        quo_c[pos +: 2] = qr[3:2];
                        rem_c           = qr[1:0];
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    num_reg[s] <= num_in;
                    quo_reg[s] <= quo_c;
                    rem_reg[s] <= rem_c;
                end
            end
        end
    endgenerate

    assign quo = bbp_pkg::coord_t'(quo_reg[bbp_pkg::DIV_STAGES-1][bbp_pkg::COORD_WIDTH-1:0]);

endmodule

>>> rtl/bbp_front.sv
// Front part: accepts events, keeps the spline state and classifies each event into commands.
module bbp_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            point_valid,
    output logic            point_stall,
    input  bbp_pkg::in_t    point,
    input  bbp_pkg::qstat_t q_stat,
    output logic            push,
    output bbp_pkg::job_t   job
);

    bbp_pkg::coord_t older_x_reg, older_x_next;
    bbp_pkg::coord_t older_y_reg, older_y_next;
    bbp_pkg::coord_t newer_x_reg, newer_x_next;
    bbp_pkg::coord_t newer_y_reg, newer_y_next;
    logic [1:0]      count_reg, count_next;
    logic            in_area_reg, in_area_next;
    logic            phase_reg, phase_next;
    logic            accept;
    logic            close_path;

    assign point_stall = q_stat.full;
    assign accept      = point_valid && !q_stat.full;

    // Classify the event and work out the next spline state.
    always_comb
    begin
        older_x_next = older_x_reg;
        older_y_next = older_y_reg;
        newer_x_next = newer_x_reg;
        newer_y_next = newer_y_reg;
        count_next   = count_reg;
        in_area_next = in_area_reg;
        phase_next   = phase_reg;
        close_path   = in_area_reg ? phase_reg : (count_reg == 2'd1);

        job.kinds = '{bbp_pkg::KIND_CLOSE, bbp_pkg::KIND_CLOSE, bbp_pkg::KIND_CLOSE};
        job.ncmd  = 2'd0;
        job.old_x = older_x_reg;
        job.old_y = older_y_reg;
        job.new_x = newer_x_reg;
        job.new_y = newer_y_reg;
        job.pt_x  = point.px;
        job.pt_y  = point.py;

        case (point.action)
            bbp_pkg::ACT_POINT:
            begin
                case (count_reg)
                    2'd0:
                    begin
                        job.kinds[0] = (in_area_reg && phase_reg) ? bbp_pkg::KIND_LINE_P
                                                                  : bbp_pkg::KIND_MOVE_P;
                        job.ncmd     = 2'd1;
                        count_next   = 2'd1;
                    end
                    2'd1:
                    begin
                        count_next = 2'd2;
                    end
                    2'd2:
                    begin
                        job.kinds[0] = bbp_pkg::KIND_LINE_SIX;
                        job.kinds[1] = bbp_pkg::KIND_CURVE;
                        job.ncmd     = 2'd2;
                        count_next   = 2'd3;
                    end
                    default:
                    begin
                        job.kinds[0] = bbp_pkg::KIND_CURVE;
                        job.ncmd     = 2'd1;
                    end
                endcase
                older_x_next = newer_x_reg;
                older_y_next = newer_y_reg;
                newer_x_next = point.px;
                newer_y_next = point.py;
            end
            bbp_pkg::ACT_LINE_START:
            begin
                count_next = 2'd0;
            end
            bbp_pkg::ACT_LINE_END:
            begin
                // The closing curve uses the newest point itself in place of a next point.
                job.pt_x = newer_x_reg;
                job.pt_y = newer_y_reg;
                case (count_reg)
                    2'd3:
                    begin
                        job.kinds[0] = bbp_pkg::KIND_CURVE;
                        job.kinds[1] = bbp_pkg::KIND_LINE_N;
                        job.ncmd     = close_path ? 2'd3 : 2'd2;
                    end
                    2'd2:
                    begin
                        job.kinds[0] = bbp_pkg::KIND_LINE_N;
                        job.ncmd     = close_path ? 2'd2 : 2'd1;
                    end
                    default:
                    begin
                        job.ncmd = close_path ? 2'd1 : 2'd0;
                    end
                endcase
                if (in_area_reg)
                begin
                    phase_next = !phase_reg;
                end
            end
            bbp_pkg::ACT_AREA_START:
            begin
                in_area_next = 1'b1;
                phase_next   = 1'b0;
            end
            bbp_pkg::ACT_AREA_END:
            begin
                in_area_next = 1'b0;
            end
            default:
            begin
            end
        endcase

        push = accept && (job.ncmd != 2'd0);
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= 2'd0;
            in_area_reg <= 1'b0;
            phase_reg   <= 1'b0;
        end
        else if (accept)
        begin
            count_reg   <= count_next;
            in_area_reg <= in_area_next;
            phase_reg   <= phase_next;
        end
    end

    // Stored points; always written before they are used.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            older_x_reg <= older_x_next;
            older_y_reg <= older_y_next;
            newer_x_reg <= newer_x_next;
            newer_y_reg <= newer_y_next;
        end
    end

endmodule

>>> rtl/bbp_queue.sv
// Short queue of classified events between the front and the back.
module bbp_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  bbp_pkg::job_t   wdata,
    input  logic            pop,
    output bbp_pkg::job_t   rdata,
    output bbp_pkg::qstat_t q_stat
);

    bbp_pkg::job_t                entry_reg [bbp_pkg::QUEUE_DEPTH];
    logic [bbp_pkg::QUEUE_AW-1:0] wptr_reg, wptr_next;
    logic [bbp_pkg::QUEUE_AW-1:0] rptr_reg, rptr_next;
    logic [bbp_pkg::QUEUE_AW:0]   count_reg, count_next;

    assign rdata        = entry_reg[rptr_reg];
    assign q_stat.full  = (count_reg == (bbp_pkg::QUEUE_AW + 1)'(bbp_pkg::QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);

    // Pointer and fill count updates.
    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == bbp_pkg::QUEUE_AW'(bbp_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                                   : wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == bbp_pkg::QUEUE_AW'(bbp_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                                   : rptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= wdata;
        end
    end

endmodule

>>> rtl/bbp_back.sv
// Back part: steps through each event's commands and computes their points.
module bbp_back (
    input  logic            clk,
    input  logic            rst_n,
    input  bbp_pkg::job_t   job,
    input  bbp_pkg::qstat_t q_stat,
    output logic            pop,
    output logic            path_valid,
    input  logic            path_stall,
    output bbp_pkg::out_t   path
);

    typedef logic signed [bbp_pkg::SUM_WIDTH-1:0] sum_t;
    typedef logic [bbp_pkg::DIV_PAD_WIDTH-1:0]    num_t;

    logic            adv;
    logic            issue;
    logic            is_last;
    bbp_pkg::kind_t  kind;
    logic [1:0]      step_reg, step_next;
    logic [1:0]      cmd_c;
    num_t            num_c [6];

    logic            va_reg;
    logic [1:0]      cmd_a_reg;
    logic            last_a_reg;
    num_t            num_a_reg [6];

    logic            v_reg    [bbp_pkg::DIV_STAGES];
    logic [1:0]      cmd_reg  [bbp_pkg::DIV_STAGES];
    logic            last_reg [bbp_pkg::DIV_STAGES];
    bbp_pkg::coord_t quo      [6];

    function automatic sum_t sx(input bbp_pkg::coord_t v);
        return sum_t'(v);
    endfunction

    // Bias a numerator so the divider sees a positive value.
    function automatic num_t biased(input sum_t u);
        return num_t'(unsigned'(u) + bbp_pkg::DIV_BIAS);
    endfunction

    // Numerator of the end point; the divider takes it by three.
    function automatic sum_t end_num(input bbp_pkg::kind_t k, input sum_t o, input sum_t n,
                                     input sum_t p);
        sum_t u;
        begin
            case (k)
                bbp_pkg::KIND_MOVE_P,
                bbp_pkg::KIND_LINE_P:   u = p + (p <<< 1);
                bbp_pkg::KIND_LINE_N:   u = n + (n <<< 1);
                bbp_pkg::KIND_LINE_SIX: u = ((o <<< 2) + o + n + sum_t'(3)) >>> 1;
                bbp_pkg::KIND_CURVE:    u = (o + (n <<< 2) + p + sum_t'(3)) >>> 1;
                default:                u = '0;
            endcase
            return u;
        end
    endfunction

    // The whole back moves unless a finished beat is held by the receiver.
    assign adv     = !(v_reg[bbp_pkg::DIV_STAGES-1] && path_stall);
    assign kind    = job.kinds[step_reg];
    assign is_last = (step_reg == job.ncmd - 2'd1);
    assign issue   = adv && !q_stat.empty;
    assign pop     = issue && is_last;

    // Command selection and numerators of the six coordinates.
    always_comb
    begin
        sum_t ox, oy, nx, ny, px, py;
        ox = sx(job.old_x);
        oy = sx(job.old_y);
        nx = sx(job.new_x);
        ny = sx(job.new_y);
        px = sx(job.pt_x);
        py = sx(job.pt_y);

        step_next = step_reg;
        if (issue)
        begin
            step_next = is_last ? 2'd0 : step_reg + 2'd1;
        end

        case (kind)
            bbp_pkg::KIND_MOVE_P:   cmd_c = bbp_pkg::CMD_MOVE;
            bbp_pkg::KIND_LINE_P,
            bbp_pkg::KIND_LINE_SIX,
            bbp_pkg::KIND_LINE_N:   cmd_c = bbp_pkg::CMD_LINE;
            bbp_pkg::KIND_CURVE:    cmd_c = bbp_pkg::CMD_CURVE;
            default:                cmd_c = bbp_pkg::CMD_CLOSE;
        endcase

        if (kind == bbp_pkg::KIND_CURVE)
        begin
            num_c[0] = biased((ox <<< 1) + nx + sum_t'(1));
            num_c[1] = biased((oy <<< 1) + ny + sum_t'(1));
            num_c[2] = biased(ox + (nx <<< 1) + sum_t'(1));
            num_c[3] = biased(oy + (ny <<< 1) + sum_t'(1));
        end
        else
        begin
            num_c[0] = biased('0);
            num_c[1] = biased('0);
            num_c[2] = biased('0);
            num_c[3] = biased('0);
        end
        num_c[4] = biased(end_num(kind, ox, nx, px));
        num_c[5] = biased(end_num(kind, oy, ny, py));
    end

    // Control of the sequencer and the valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 2'd0;
            va_reg   <= 1'b0;
            for (int k = 0; k < bbp_pkg::DIV_STAGES; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else
        begin
            step_reg <= step_next;
            if (adv)
            begin
                va_reg   <= !q_stat.empty;
                v_reg[0] <= va_reg;
                for (int k = 1; k < bbp_pkg::DIV_STAGES; k++)
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // Numerator stage and the command that travels beside the divider.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cmd_a_reg  <= cmd_c;
            last_a_reg <= is_last;
            for (int k = 0; k < 6; k++)
            begin
                num_a_reg[k] <= num_c[k];
            end
            cmd_reg[0]  <= cmd_a_reg;
            last_reg[0] <= last_a_reg;
            for (int k = 1; k < bbp_pkg::DIV_STAGES; k++)
            begin
                cmd_reg[k]  <= cmd_reg[k-1];
                last_reg[k] <= last_reg[k-1];
            end
        end
    end

    genvar c;
    generate
        for (c = 0; c < 6; c++) begin : g_div
            bbp_div3 u_div3 (
                .clk (clk),
                .adv (adv),
                .num (num_a_reg[c]),
                .quo (quo[c])
            );
        end
    endgenerate

    assign path_valid    = v_reg[bbp_pkg::DIV_STAGES-1];
    assign path.command  = cmd_reg[bbp_pkg::DIV_STAGES-1];
    assign path.ctrl1_x  = quo[0];
    assign path.ctrl1_y  = quo[1];
    assign path.ctrl2_x  = quo[2];
    assign path.ctrl2_y  = quo[3];
    assign path.end_x    = quo[4];
    assign path.end_y    = quo[5];
    assign path.last     = last_reg[bbp_pkg::DIV_STAGES-1];

endmodule

>>> rtl/bspline_to_bezier_path_core.sv
// Top level of the uniform cubic B-spline to Bezier path converter.
//
// Input channel (point_valid, point_stall, point): one event per beat, either a
// control point or a line or area start or end. Output channel (path_valid,
// path_stall, path): one path command per beat: move, line, cubic Bezier or
// close, with last set on the final command that an event causes.
// Events that cause no command are absorbed without an output beat.
// Each command's route: its event is written into the queue; when issued, the command
// passes one numerator stage, then the divide-by-three pipeline, two quotient bits
// per step and six steps per stage. Throughput: one event per cycle on the input
// while the queue is not full, one command per cycle on the output while path_stall
// is low; an event holds the command sequencer until its last command is issued.
// A four-entry queue sits between the classifying front and the computing back,
// so the input keeps accepting while the output is stalled until the queue fills;
// point_stall is high exactly when it is full.
// When path_stall is high while a beat is presented, the output beat and all back stages hold.
// Reset clears the point count, area state, queue and all valid bits.
module bspline_to_bezier_path_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          point_valid,
    output logic          point_stall,
    input  bbp_pkg::in_t  point,
    output logic          path_valid,
    input  logic          path_stall,
    output bbp_pkg::out_t path
);

    logic            q_push;
    logic            q_pop;
    bbp_pkg::job_t   q_wdata;
    bbp_pkg::job_t   q_rdata;
    bbp_pkg::qstat_t q_stat;

    bbp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .point       (point),
        .q_stat      (q_stat),
        .push        (q_push),
        .job         (q_wdata)
    );

    bbp_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wdata  (q_wdata),
        .pop    (q_pop),
        .rdata  (q_rdata),
        .q_stat (q_stat)
    );

    bbp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job        (q_rdata),
        .q_stat     (q_stat),
        .pop        (q_pop),
        .path_valid (path_valid),
        .path_stall (path_stall),
        .path       (path)
    );

`ifndef SYNTHESIS
    // The front never writes into a full queue.
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("queue written while full");

    // The back only retires an event that is present.
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("queue read while empty");

    // Commands of one event leave on consecutive beats.
    a_burst_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (path_valid && !path_stall && !path.last) |=> path_valid)
        else $error("gap inside the commands of one event");

    // A close command carries no coordinates (checked on the end point, ctrl1_x and ctrl2_y).
    a_close_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (path_valid && path.command == bbp_pkg::CMD_CLOSE) |->
        (path.end_x == '0 && path.end_y == '0 && path.ctrl1_x == '0 && path.ctrl2_y == '0))
        else $error("close command with nonzero coordinates");
`endif

endmodule

>>> tb/bbp_path_checker.sv
// Path command checker: predicts the commands for each event beat and compares them.
`timescale 1ns / 1ps

module bbp_path_checker
    import bbp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic point_valid,
    input  logic point_stall,
    input  in_t  point,
    input  logic path_valid,
    input  logic path_stall,
    input  out_t path,
    output int   errors,
    output int   pending,
    output int   commands_seen
);

    // Shadow copy of the converter state.
    coord_t     old_x;
    coord_t     old_y;
    coord_t     new_x;
    coord_t     new_y;
    logic [1:0] pt_count;
    logic       in_area;
    logic       line_phase;

    // Commands predicted but not yet seen on the path channel, oldest first.
    out_t expected_cmds[$];

    // Weighted average (wa*a + wb*b + wc*c) / d rounded to nearest, halves upward.
    function automatic coord_t round_avg(input coord_t a, input int wa, input coord_t b,
                                         input int wb, input coord_t c, input int wc,
                                         input int d);
        longint num;
        longint den;
        longint q;
        num = 2 * (wa * longint'(a) + wb * longint'(b) + wc * longint'(c)) + d;
        den = 2 * d;
        q = num / den;
        if ((num % den) != 0 && num < 0)
        begin
            q = q - 1;
        end
        return coord_t'(q);
    endfunction

    function automatic out_t path_cmd(input logic [1:0] cmd, input coord_t c1x,
                                      input coord_t c1y, input coord_t c2x,
                                      input coord_t c2y, input coord_t ex, input coord_t ey);
        out_t c;
        c.command = cmd;
        c.ctrl1_x = c1x;
        c.ctrl1_y = c1y;
        c.ctrl2_x = c2x;
        c.ctrl2_y = c2y;
        c.end_x   = ex;
        c.end_y   = ey;
        c.last    = 1'b0;
        return c;
    endfunction

    // Bezier segment of the span between the stored points, ending toward p.
    function automatic out_t bezier_to(input coord_t px, input coord_t py);
        return path_cmd(CMD_CURVE,
                        round_avg(old_x, 2, new_x, 1, '0, 0, 3),
                        round_avg(old_y, 2, new_y, 1, '0, 0, 3),
                        round_avg(old_x, 1, new_x, 2, '0, 0, 3),
                        round_avg(old_y, 1, new_y, 2, '0, 0, 3),
                        round_avg(old_x, 1, new_x, 4, px, 1, 6),
                        round_avg(old_y, 1, new_y, 4, py, 1, 6));
    endfunction

    // Advance the shadow state by one event and queue the commands it causes.
    task automatic predict_event(input in_t ev);
        out_t cmds[$];
        case (ev.action)
            ACT_POINT:
            begin
                if (pt_count == 2'd0)
                begin
                    cmds.push_back(path_cmd((in_area && line_phase) ? CMD_LINE : CMD_MOVE,
                                            '0, '0, '0, '0, ev.px, ev.py));
                    pt_count = 2'd1;
                end
                else if (pt_count == 2'd1)
                begin
                    pt_count = 2'd2;
                end
                else
                begin
                    // The third point of a line first draws the lead-in segment.
                    if (pt_count == 2'd2)
                    begin
                        cmds.push_back(path_cmd(CMD_LINE, '0, '0, '0, '0,
                                                round_avg(old_x, 5, new_x, 1, '0, 0, 6),
                                                round_avg(old_y, 5, new_y, 1, '0, 0, 6)));
                        pt_count = 2'd3;
                    end
                    cmds.push_back(bezier_to(ev.px, ev.py));
                end
                old_x = new_x;
                old_y = new_y;
                new_x = ev.px;
                new_y = ev.py;
            end
            ACT_LINE_START:
            begin
                pt_count = 2'd0;
            end
            ACT_LINE_END:
            begin
                if (pt_count == 2'd3)
                begin
                    cmds.push_back(bezier_to(new_x, new_y));
                end
                if (pt_count >= 2'd2)
                begin
                    cmds.push_back(path_cmd(CMD_LINE, '0, '0, '0, '0, new_x, new_y));
                end
                // Inside an area every second line closes; outside only a lone point does.
                if (in_area ? line_phase : (pt_count == 2'd1))
                begin
                    cmds.push_back(path_cmd(CMD_CLOSE, '0, '0, '0, '0, '0, '0));
                end
                if (in_area)
                begin
                    line_phase = ~line_phase;
                end
            end
            ACT_AREA_START:
            begin
                in_area    = 1'b1;
                line_phase = 1'b0;
            end
            ACT_AREA_END:
            begin
                in_area = 1'b0;
            end
            default:
            begin
            end
        endcase
        if (cmds.size() > 0)
        begin
            cmds[cmds.size() - 1].last = 1'b1;
        end
        foreach (cmds[i])
        begin
            expected_cmds.push_back(cmds[i]);
        end
    endtask

    task automatic compare_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    task automatic check_command(input out_t got);
        out_t want;
        commands_seen++;
        if (expected_cmds.size() == 0)
        begin
            $error("path command %0d arrived with nothing expected", got.command);
            errors++;
        end
        else
        begin
            want = expected_cmds.pop_front();
            compare_field("command", want.command, got.command);
            compare_field("ctrl1_x", want.ctrl1_x, got.ctrl1_x);
            compare_field("ctrl1_y", want.ctrl1_y, got.ctrl1_y);
            compare_field("ctrl2_x", want.ctrl2_x, got.ctrl2_x);
            compare_field("ctrl2_y", want.ctrl2_y, got.ctrl2_y);
            compare_field("end_x", want.end_x, got.end_x);
            compare_field("end_y", want.end_y, got.end_y);
            compare_field("last", want.last, got.last);
        end
    endtask

    // Outputs are checked before the same edge's event is predicted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            old_x         = '0;
            old_y         = '0;
            new_x         = '0;
            new_y         = '0;
            pt_count      = 2'd0;
            in_area       = 1'b0;
            line_phase    = 1'b0;
            errors        = 0;
            commands_seen = 0;
            expected_cmds.delete();
            pending <= 0;
        end
        else
        begin
            if (path_valid && !path_stall)
            begin
                check_command(path);
            end
            if (point_valid && !point_stall)
            begin
                predict_event(point);
            end
            pending <= expected_cmds.size();
        end
    end

endmodule

>>> tb/testbench.sv
// Testbench top: clock, reset, event stimulus, output stalls and the verdict.
`timescale 1ns / 1ps

module testbench;
    import bbp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int TOTAL_ITEMS = 130;
    localparam int MAX_WAIT    = 17;

    logic clk         = 1'b0;
    logic rst_n       = 1'b0;
    logic point_valid = 1'b0;
    in_t  point       = '0;
    logic path_stall  = 1'b0;
    logic point_stall;
    logic path_valid;
    out_t path;

    int errors;
    int pending;
    int commands_seen;
    int n_items   = 0;
    int n_points  = 0;
    int stall_left = 0;
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;

    always #5 clk = ~clk;

    bspline_to_bezier_path_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .point_valid(point_valid),
        .point_stall(point_stall),
        .point      (point),
        .path_valid (path_valid),
        .path_stall (path_stall),
        .path       (path)
    );

    bbp_path_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .point_valid  (point_valid),
        .point_stall  (point_stall),
        .point        (point),
        .path_valid   (path_valid),
        .path_stall   (path_stall),
        .path         (path),
        .errors       (errors),
        .pending      (pending),
        .commands_seen(commands_seen)
    );

    // Coordinates: full-range, near zero for rounding, the extremes, and mid-size.
    function automatic coord_t rand_coord();
        coord_t c;
        case ($urandom_range(0, 5))
            0: c = coord_t'(int'($urandom_range(0, 16)) - 8);
            1:
            begin
                case ($urandom_range(0, 3))
                    0: c = coord_t'(32'h8000_0000);
                    1: c = coord_t'(32'h7fff_ffff);
                    2: c = '0;
                    default: c = '1;
                endcase
            end
            2: c = coord_t'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
            default: c = coord_t'($urandom);
        endcase
        return c;
    endfunction

    // Present one event beat after a random gap and hold it until it is taken.
    task automatic send_item(input logic [2:0] act, input coord_t x, input coord_t y);
        int   gap;
        in_t  beat;
        if ($urandom_range(0, 11) == 0)
        begin
            tx_steady = ~tx_steady;
        end
        gap = tx_steady ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            point_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        beat.action = act;
        beat.px     = x;
        beat.py     = y;
        point       <= beat;
        point_valid <= 1'b1;
        do
            @(posedge clk);
        while (point_stall);
        n_items++;
        if (act == ACT_POINT)
        begin
            n_points++;
        end
    endtask

    // Non-point events carry random coordinates that must be ignored.
    task automatic send_event(input logic [2:0] act);
        send_item(act, rand_coord(), rand_coord());
    endtask

    task automatic send_point(input coord_t x, input coord_t y);
        send_item(ACT_POINT, x, y);
    endtask

    // One well-formed line: start, a few points, end.
    task automatic draw_line();
        int k;
        k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
        send_event(ACT_LINE_START);
        repeat (k) send_point(rand_coord(), rand_coord());
        send_event(ACT_LINE_END);
    endtask

    // Output side: after each taken beat, stall for a random number of cycles.
    always @(posedge clk)
    begin : path_receiver
        int hold;
        hold = stall_left;
        if (path_valid && !path_stall)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                rx_steady = ~rx_steady;
            end
            hold = rx_steady ? 0 : $urandom_range(0, MAX_WAIT);
        end
        if (hold > 0)
        begin
            path_stall <= 1'b1;
            stall_left <= hold - 1;
        end
        else
        begin
            path_stall <= 1'b0;
            stall_left <= 0;
        end
    end

    // Watchdog on the whole run.
    initial
    begin : watchdog
        int n;
        for (n = 0; n < CYCLE_LIMIT; n++)
        begin
            @(posedge clk);
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : stimulus
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A line end with no points outside an area draws nothing.
        send_event(ACT_LINE_END);

        // Four points, two at the coordinate extremes: move, lead-in, curves, tail.
        send_event(ACT_LINE_START);
        send_point(coord_t'(32'h7fff_ffff), coord_t'(32'h8000_0000));
        send_point(coord_t'(32'h8000_0000), coord_t'(32'h7fff_ffff));
        send_point(coord_t'(3), coord_t'(-3));
        send_point(coord_t'(-1), coord_t'(1));
        send_event(ACT_LINE_END);

        // A lone point outside an area closes the path.
        send_event(ACT_LINE_START);
        send_point(coord_t'(-3), coord_t'(3));
        send_event(ACT_LINE_END);

        // Two points give a move and a straight line.
        send_event(ACT_LINE_START);
        send_point('0, '0);
        send_point(coord_t'(5), coord_t'(-5));
        send_event(ACT_LINE_END);

        // An area with two lines: the second starts with a line to and closes.
        send_event(ACT_AREA_START);
        send_event(ACT_LINE_START);
        send_point(coord_t'(32'h0001_0000), coord_t'(32'hffff_0000));
        send_point(coord_t'(32'h0002_8000), coord_t'(32'h0000_0001));
        send_point(coord_t'(32'hfffd_0000), coord_t'(32'h7fff_0000));
        send_event(ACT_LINE_END);
        send_event(ACT_LINE_START);
        send_point(coord_t'(32'h1234_5678), coord_t'(32'h8765_4321));
        send_event(ACT_LINE_END);
        send_event(ACT_AREA_END);

        // Unused action codes must be ignored.
        send_event(3'd5);
        send_event(3'd6);
        send_event(3'd7);

        // Random part: mostly well-formed lines and areas, some loose events,
        // until about TOTAL_ITEMS events have been sent in all.
        while (n_items < TOTAL_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0, 1: send_item(3'($urandom_range(0, 7)), rand_coord(), rand_coord());
                2, 3:
                begin
                    send_event(ACT_AREA_START);
                    repeat ($urandom_range(1, 4)) draw_line();
                    send_event(ACT_AREA_END);
                end
                default: draw_line();
            endcase
        end
        point_valid <= 1'b0;

        // Drain the outstanding commands, then watch for strays.
        do
            @(posedge clk);
        while (pending != 0);
        repeat (40) @(posedge clk);

        $display("Sent %0d events (%0d points) in lines and areas, with random gaps",
                 n_items, n_points);
        $display("and output stalls; %0d path commands were checked.", commands_seen);
        if (errors == 0 && pending == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
